// ===== rtl/sids_pkg.sv =====
// ----------------------------------------------------------------------------
// sids_pkg
// Shared types and constants for the sorted ID set difference engine.
// ----------------------------------------------------------------------------
package sids_pkg;

    localparam int ID_BITS        = 20;
    localparam int CNT_BITS       = 13;
    localparam int CFG_BITS       = 2;
    localparam int NUM_LABELS_DEF = 2;
    localparam int MAX_ITEMS_DEF  = 1024;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(2);
    localparam logic [CNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        REQ_APPEND_OLD = 2'd0,
        REQ_APPEND_NEW = 2'd1,
        REQ_CLEAR      = 2'd2,
        REQ_PULL       = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_REJECTED = 3'd1,
        KIND_ADD      = 3'd2,
        KIND_REMOVE   = 3'd3,
        KIND_DONE     = 3'd4
    } t_kind;

    typedef struct packed {
        t_req               req_type;
        logic               label;
        logic [ID_BITS-1:0] instance_id;
    } t_cmd;

    typedef struct packed {
        t_kind               kind;
        logic                diff_label;
        logic [ID_BITS-1:0]  diff_id;
        logic [CNT_BITS-1:0] running_total;
        logic [CNT_BITS-1:0] removal_count;
    } t_result;

endpackage

// ===== rtl/sorted_id_set_difference.sv =====
// ----------------------------------------------------------------------------
// sorted_id_set_difference
// Per-label old/new ascending ID lists with a pull-driven merge that reports
// the IDs to add and to remove.
// ----------------------------------------------------------------------------
// Command channel: a transaction is taken on a rising edge with start high and
//   busy low; i_cmd carries request type, label and instance ID. Each command
//   yields one result, shown on o_result for one cycle with o_strobe high. The
//   receiver has no back-pressure and must take every strobe.
// Config channel: i_cfg_valid/o_cfg_ready write labels_in_use; ready is high
//   whenever the engine is idle. labels_in_use resets to 2.
// Sequencing, from accept to result:
//   clear answers straight from idle; append into an empty list answers from
//   the load stage, else a check stage follows (last stored ID read back);
//   pull walks list pairs and passes over exhausted labels; it may end in done.
//   Each pair reads each list once through its registered read port.
// Command flow: one command at a time; the next is taken while the previous
//   result is on the ports.
// Reset: fill counts, cursors and totals clear; no memory sweep, since
//   entries at or above a list's fill are never used.
// ----------------------------------------------------------------------------
module sorted_id_set_difference #(
    parameter int NUM_LABELS = sids_pkg::NUM_LABELS_DEF,
    parameter int MAX_ITEMS  = sids_pkg::MAX_ITEMS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sids_pkg::t_cmd                i_cmd,
    output logic                          o_strobe,
    output sids_pkg::t_result             o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sids_pkg::CFG_BITS-1:0] i_cfg_data
);

    localparam int DEPTH = NUM_LABELS * MAX_ITEMS;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(MAX_ITEMS + 1);         // fill / cursor width
    localparam int LW    = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
    localparam int CLW   = $clog2(NUM_LABELS + 1);        // cursor label width
    localparam int IDW   = sids_pkg::ID_BITS;
    localparam int CW    = sids_pkg::CNT_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_L_EVAL,
        S_L_CHK,
        S_P_EVAL,
        S_P_CMP
    } t_state;

    t_state                 r_state;
    sids_pkg::t_cmd         r_req;
    logic [sids_pkg::CFG_BITS-1:0] r_cfg;
    logic [FW-1:0]          r_old_fill [NUM_LABELS];
    logic [FW-1:0]          r_new_fill [NUM_LABELS];
    logic [CLW-1:0]         r_cur_lab;
    logic [FW-1:0]          r_cur_old;
    logic [FW-1:0]          r_cur_new;
    logic [CW-1:0]          r_tot;
    logic [CW-1:0]          r_rem;
    logic                   r_have_old;
    logic                   r_have_new;
    logic                   r_strobe;
    sids_pkg::t_result      r_res;

    // list memories, one read and one write port each
    logic [IDW-1:0]         old_mem [DEPTH];
    logic [IDW-1:0]         new_mem [DEPTH];
    logic [IDW-1:0]         r_old_rd;
    logic [IDW-1:0]         r_new_rd;

    logic                   w_lab_ok;
    logic [LW-1:0]          w_fidx;
    logic [FW-1:0]          w_old_n;
    logic [FW-1:0]          w_new_n;
    logic                   w_is_old;
    logic [FW-1:0]          w_n;
    logic                   w_full;
    logic [AW-1:0]          w_base;
    logic [AW-1:0]          w_last_addr;
    logic [AW-1:0]          w_app_addr;
    logic [AW-1:0]          w_rd_old_addr;
    logic [AW-1:0]          w_rd_new_addr;
    logic [IDW-1:0]         w_rd_last;
    logic                   w_id_gt;
    logic                   w_we;
    logic [CLW-1:0]         w_active;
    logic                   w_in_range;
    logic                   w_have_old;
    logic                   w_have_new;
    logic [CW-1:0]          w_tot_inc;
    logic [CW-1:0]          w_rem_inc;

    // ---- active label count: register value capped at NUM_LABELS
    always_comb begin
        if (32'(r_cfg) > NUM_LABELS) begin
            w_active = CLW'(NUM_LABELS);
        end else begin
            w_active = CLW'(r_cfg);
        end
    end

    // ---- fill lookup, one index shared by load and pull phases
    assign w_lab_ok = (32'(r_req.label) < NUM_LABELS);
    assign w_is_old = (r_req.req_type == sids_pkg::REQ_APPEND_OLD);

    always_comb begin
        if (r_state == S_P_EVAL) begin
            w_fidx = r_cur_lab[LW-1:0];
        end else if (w_lab_ok) begin
            w_fidx = LW'(r_req.label);
        end else begin
            w_fidx = '0;
        end
    end

    assign w_old_n = r_old_fill[w_fidx];
    assign w_new_n = r_new_fill[w_fidx];
    assign w_n     = w_is_old ? w_old_n : w_new_n;
    assign w_full  = (32'(w_n) >= MAX_ITEMS);

    // label-major layout: entry = label * MAX_ITEMS + index
    assign w_base      = AW'(32'(w_fidx) * MAX_ITEMS);
    assign w_last_addr = w_base + AW'(w_n - FW'(1));
    assign w_app_addr  = w_base + AW'(w_n);

    assign w_rd_old_addr = (r_state == S_P_EVAL) ? (w_base + AW'(r_cur_old)) : w_last_addr;
    assign w_rd_new_addr = (r_state == S_P_EVAL) ? (w_base + AW'(r_cur_new)) : w_last_addr;

    assign w_rd_last = w_is_old ? r_old_rd : r_new_rd;
    assign w_id_gt   = (r_req.instance_id > w_rd_last);

    // append write: straight in for an empty list, else after the order check
    assign w_we = ((r_state == S_L_EVAL) && w_lab_ok && !w_full && (w_n == '0))
               || ((r_state == S_L_CHK) && w_id_gt);

    assign w_in_range = (r_cur_lab < w_active);
    assign w_have_old = (r_cur_old < w_old_n);
    assign w_have_new = (r_cur_new < w_new_n);

    assign w_tot_inc = (r_tot == sids_pkg::COUNT_MAX) ? r_tot : r_tot + CW'(1);
    assign w_rem_inc = (r_rem == sids_pkg::COUNT_MAX) ? r_rem : r_rem + CW'(1);

    // ---- memories
    always_ff @(posedge i_clk) begin
        if (w_we && w_is_old) begin
            old_mem[w_app_addr] <= r_req.instance_id;
        end
        r_old_rd <= old_mem[w_rd_old_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_we && !w_is_old) begin
            new_mem[w_app_addr] <= r_req.instance_id;
        end
        r_new_rd <= new_mem[w_rd_new_addr];
    end

    // ---- config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= sids_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg <= i_cfg_data;
        end
    end

    // ---- control FSM and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_strobe  <= 1'b0;
            r_cur_lab <= '0;
            r_cur_old <= '0;
            r_cur_new <= '0;
            r_tot     <= '0;
            r_rem     <= '0;
            for (int k = 0; k < NUM_LABELS; k++) begin
                r_old_fill[k] <= '0;
                r_new_fill[k] <= '0;
            end
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req <= i_cmd;
                        case (i_cmd.req_type)
                            sids_pkg::REQ_APPEND_OLD,
                            sids_pkg::REQ_APPEND_NEW: begin
                                r_cur_lab <= '0;
                                r_cur_old <= '0;
                                r_cur_new <= '0;
                                r_tot     <= '0;
                                r_rem     <= '0;
                                r_state   <= S_L_EVAL;
                            end
                            sids_pkg::REQ_CLEAR: begin
                                for (int k = 0; k < NUM_LABELS; k++) begin
                                    r_old_fill[k] <= '0;
                                    r_new_fill[k] <= '0;
                                end
                                r_cur_lab <= '0;
                                r_cur_old <= '0;
                                r_cur_new <= '0;
                                r_tot     <= '0;
                                r_rem     <= '0;
                                r_strobe  <= 1'b1;
                                r_res     <= '{sids_pkg::KIND_ACCEPTED, 1'b0, '0, '0, '0};
                            end
                            sids_pkg::REQ_PULL: begin
                                r_state <= S_P_EVAL;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_L_EVAL: begin
                    r_state <= S_IDLE;
                    if (!w_lab_ok || w_full) begin
                        r_strobe <= 1'b1;
                        r_res    <= '{sids_pkg::KIND_REJECTED, 1'b0, '0, '0, '0};
                    end else if (w_n == '0) begin
                        if (w_is_old) begin
                            r_old_fill[w_fidx] <= w_n + FW'(1);
                        end else begin
                            r_new_fill[w_fidx] <= w_n + FW'(1);
                        end
                        r_strobe <= 1'b1;
                        r_res    <= '{sids_pkg::KIND_ACCEPTED, 1'b0, '0, '0, '0};
                    end else begin
                        // last stored ID is being read
                        r_state <= S_L_CHK;
                    end
                end

                S_L_CHK: begin
                    r_state  <= S_IDLE;
                    r_strobe <= 1'b1;
                    if (w_id_gt) begin
                        if (w_is_old) begin
                            r_old_fill[w_fidx] <= w_n + FW'(1);
                        end else begin
                            r_new_fill[w_fidx] <= w_n + FW'(1);
                        end
                        r_res <= '{sids_pkg::KIND_ACCEPTED, 1'b0, '0, '0, '0};
                    end else begin
                        r_res <= '{sids_pkg::KIND_REJECTED, 1'b0, '0, '0, '0};
                    end
                end

                S_P_EVAL: begin
                    if (!w_in_range) begin
                        r_state  <= S_IDLE;
                        r_strobe <= 1'b1;
                        r_res    <= '{sids_pkg::KIND_DONE, 1'b0, '0, r_tot, r_rem};
                    end else if (!w_have_old && !w_have_new) begin
                        // label exhausted, move on
                        r_cur_lab <= r_cur_lab + CLW'(1);
                        r_cur_old <= '0;
                        r_cur_new <= '0;
                    end else begin
                        r_have_old <= w_have_old;
                        r_have_new <= w_have_new;
                        r_state    <= S_P_CMP;
                    end
                end

                S_P_CMP: begin
                    if (r_have_old && r_have_new && (r_old_rd == r_new_rd)) begin
                        // shared ID: skip silently
                        r_cur_old <= r_cur_old + FW'(1);
                        r_cur_new <= r_cur_new + FW'(1);
                        r_state   <= S_P_EVAL;
                    end else if (r_have_new && (!r_have_old || (r_new_rd < r_old_rd))) begin
                        r_cur_new <= r_cur_new + FW'(1);
                        r_tot     <= w_tot_inc;
                        r_strobe  <= 1'b1;
                        r_res     <= '{sids_pkg::KIND_ADD, r_cur_lab[0], r_new_rd,
                                       w_tot_inc, r_rem};
                        r_state   <= S_IDLE;
                    end else begin
                        r_cur_old <= r_cur_old + FW'(1);
                        r_tot     <= w_tot_inc;
                        r_rem     <= w_rem_inc;
                        r_strobe  <= 1'b1;
                        r_res     <= '{sids_pkg::KIND_REMOVE, r_cur_lab[0], r_old_rd,
                                       w_tot_inc, w_rem_inc};
                        r_state   <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;
    assign o_strobe    = r_strobe;
    assign o_result    = r_res;

    // ---- assertions
    // a result is only ever shown once the engine is back to idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // removals are a subset of all differences
    a_rem_le_tot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.removal_count <= o_result.running_total))
        else $error("removal count above total difference");

    // add/remove reports always carry a nonzero running total
    a_diff_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ((o_result.kind == sids_pkg::KIND_ADD)
                   || (o_result.kind == sids_pkg::KIND_REMOVE)))
        |-> (o_result.running_total != '0))
        else $error("difference reported without count");

    // merge cursor never runs past the list it walks
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P_EVAL && w_in_range) |-> (r_cur_old <= w_old_n && r_cur_new <= w_new_n))
        else $error("merge cursor beyond fill");

endmodule
